### sv/abc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abc_pkg: shared types and constants of the archive block cipher
// Holds the register indexes, the seed constants and the fixed crypt table,
// which is built at elaboration from the linear congruential generation rule.
// ----------------------------------------------------------------------------
package abc_pkg;

    typedef logic [31:0]            t_word;
    typedef logic [255:0][31:0]     t_crypt_table;

    // Configuration register indexes
    localparam logic CFG_KEY  = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    // Mode codes
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    localparam t_word SEED_TWO_INIT = 32'hEEEE_EEEE;
    localparam t_word SEED_ONE_ADD  = 32'h1111_1111;
    localparam int    SEED_ONE_SHL  = 'h15;
    localparam int    SEED_ONE_SHR  = 'h0B;

    // Table generator constants
    localparam t_word LCG_START = 32'h0010_0001;
    localparam t_word LCG_MUL   = 32'd125;
    localparam t_word LCG_MOD   = 32'h002A_AAAB;
    localparam t_word LCG_INC   = 32'd3;
    localparam int    LCG_ROWS  = 5;
    localparam int    ROW_KEPT  = 4;

    // Build the table: each column draws five (hi, lo) pairs, keep the last row
    function automatic t_crypt_table build_crypt_table();
        t_crypt_table tab;
        t_word        s;
        t_word        hi;
        t_word        lo;
        s   = LCG_START;
        tab = '0;
        for (int col = 0; col < 256; col++) begin
            for (int row = 0; row < LCG_ROWS; row++) begin
                s  = (s * LCG_MUL + LCG_INC) % LCG_MOD;
                hi = {s[15:0], 16'h0000};
                s  = (s * LCG_MUL + LCG_INC) % LCG_MOD;
                lo = {16'h0000, s[15:0]};
                if (row == ROW_KEPT) begin
                    tab[col] = hi | lo;
                end
            end
        end
        return tab;
    endfunction

    localparam t_crypt_table CRYPT_TABLE = build_crypt_table();

endpackage

### sv/archive_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_block_cipher: word-stream block cipher for archive blocks
// Encrypts or decrypts one 32-bit word per transfer under two running seeds.
// ----------------------------------------------------------------------------
// One word is accepted every clock cycle while the output is not stalled, and
// its result passes from the input register to the output register: the
// seed update, table read and XOR settle in a single pass between the two
// registers. The seed recurrence closes within that one pass, so throughput
// stays at one word per cycle while the output is not stalled. The seeds
// reload from the key register and 0xEEEEEEEE on the first word after reset
// and after each word marked last. Key and mode are to be written by the user
// only while the block is idle; the block itself does not enforce this. There
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
module archive_block_cipher
    import abc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic        i_last,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_word,
    output logic        o_last_out
);

    t_word r_key;
    logic  r_mode;

    logic  r_in_valid;
    t_word r_in_data;
    logic  r_in_last;

    logic  r_out_valid;
    t_word r_out_word;
    logic  r_out_last;

    t_word r_seed_one;
    t_word r_seed_two;
    logic  r_block_start;

    logic  out_free;
    logic  move;
    logic  in_free;
    logic  in_xfer;

    t_word seed_one;
    t_word seed_two;
    t_word seed_two_sum;
    t_word result;
    t_word plain;
    t_word n_seed_one;
    t_word n_seed_two;

    // Handshake: the output register frees when empty or taken
    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_in_valid && out_free;
    assign in_free    = !r_in_valid || move;
    assign in_xfer    = i_in_valid && in_free;
    assign o_in_stall = !in_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_mode <= MODE_ENCRYPT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KEY:  r_key  <= i_cfg_data;
                CFG_MODE: r_mode <= i_cfg_data[0];
                default:  r_key  <= r_key;
            endcase
        end
    end

    // Input register: load on transfer, drop when moved on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_data <= i_data_word;
            r_in_last <= i_last;
        end
    end

    // Cipher step: reload seeds at block start, then one table round
    always_comb begin
        seed_one     = r_block_start ? r_key : r_seed_one;
        seed_two     = r_block_start ? SEED_TWO_INIT : r_seed_two;
        seed_two_sum = seed_two + CRYPT_TABLE[seed_one[7:0]];
        result       = r_in_data ^ (seed_one + seed_two_sum);
        plain        = (r_mode == MODE_DECRYPT) ? result : r_in_data;
        n_seed_one   = ((~seed_one << SEED_ONE_SHL) + SEED_ONE_ADD)
                       | (seed_one >> SEED_ONE_SHR);
        n_seed_two   = plain + seed_two_sum + (seed_two_sum << 5) + LCG_INC;
    end

    // Advance seeds and arm the reload after the last word of a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_start <= 1'b1;
        end else if (move) begin
            r_block_start <= r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_seed_one <= n_seed_one;
            r_seed_two <= n_seed_two;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_word <= result;
            r_out_last <= r_in_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_word = r_out_word;
    assign o_last_out    = r_out_last;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the archive block cipher
// A scoreboard predictor with its own crypt table and seed pair tracks every
// accepted word and checks each result in order. Encrypt phases are replayed
// as decrypt phases under the same key. Sender idle and receiver stall vary
// by phase, and key and mode are rewritten between phases, often mid-block.
// ----------------------------------------------------------------------------
module tb;
    import abc_pkg::*;

    localparam int    WORDS_PER_PHASE = 190;
    localparam int    N_PHASES        = 8;
    localparam int    STALL_LIMIT     = 4000;
    localparam t_word SEED_B_START    = 32'hEEEE_EEEE;
    localparam t_word SEED_A_ADD      = 32'h1111_1111;

    typedef struct packed {
        t_word word;
        logic  last;
    } t_block_word;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = CFG_KEY;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_data_word = '0;
    logic        i_last      = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_result_word;
    logic        o_last_out;

    // Words waiting to be sent, results awaited, ciphertext kept for replay
    t_block_word word_feed_q[$];
    t_block_word cipher_expect_q[$];
    t_block_word cipher_log[$];

    // Predictor state
    t_word mix_table[256];
    t_word seed_a;
    t_word seed_b;
    t_word key_shadow   = '0;
    logic  mode_shadow  = MODE_ENCRYPT;
    logic  block_fresh  = 1'b1;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int err_count       = 0;
    int n_enc_words     = 0;
    int n_dec_words     = 0;
    int n_blocks        = 0;
    int quiet_cycles    = 0;

    archive_block_cipher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_word   (i_data_word),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_word (o_result_word),
        .o_last_out    (o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Fill the mix table: each column draws five (hi, lo) pairs, keep the fifth
    function automatic void build_mix_table();
        logic [63:0] s;
        logic [15:0] hi;
        s = 64'h0010_0001;
        for (int col = 0; col < 256; col++) begin
            for (int row = 0; row < 5; row++) begin
                s  = (s * 64'd125 + 64'd3) % 64'h2A_AAAB;
                hi = s[15:0];
                s  = (s * 64'd125 + 64'd3) % 64'h2A_AAAB;
                if (row == 4) begin
                    mix_table[col] = {hi, s[15:0]};
                end
            end
        end
    endfunction

    // Advance the seed pair by one word and return the transformed word
    function automatic t_word cipher_word(input t_word data, input logic last);
        t_word res;
        t_word plain;
        if (block_fresh) begin
            seed_a      = key_shadow;
            seed_b      = SEED_B_START;
            block_fresh = 1'b0;
        end
        seed_b = seed_b + mix_table[seed_a[7:0]];
        res    = data ^ (seed_a + seed_b);
        plain  = (mode_shadow == MODE_DECRYPT) ? res : data;
        seed_a = (((~seed_a) << 21) + SEED_A_ADD) | (seed_a >> 11);
        seed_b = plain + seed_b + (seed_b << 5) + 32'd3;
        if (last) begin
            block_fresh = 1'b1;
        end
        return res;
    endfunction

    // Write one register while the block is idle
    task automatic write_reg(input logic idx, input t_word val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_KEY) begin
            key_shadow = val;
        end else begin
            mode_shadow = val[0];
        end
    endtask

    task automatic push_word(input t_word w, input logic last);
        t_block_word item;
        item.word = w;
        item.last = last;
        word_feed_q.push_back(item);
    endtask

    // Queue random blocks, mostly short, with single-word blocks mixed in
    task automatic queue_random_blocks(input int n_words);
        int    blk_len;
        t_word w;
        while (n_words > 0) begin
            blk_len = ($urandom_range(4) == 0) ? 1 : $urandom_range(24, 2);
            for (int k = 0; k < blk_len && n_words > 0; k++) begin
                case ($urandom_range(15))
                    0:       w = '0;
                    1:       w = '1;
                    default: w = $urandom;
                endcase
                push_word(w, (k == blk_len - 1) || (n_words == 1));
                n_words--;
            end
        end
    endtask

    // Wait until every word is sent and every result has come back
    task automatic drain();
        while (word_feed_q.size() != 0 || i_in_valid || cipher_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Input driver: hold a stalled transfer, otherwise send or idle
    always @(posedge i_clk) begin : drive_words
        t_block_word nxt;
        t_block_word predicted;
        logic        take;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take = i_in_valid && !o_in_stall;
            if (take) begin
                predicted.word = cipher_word(i_data_word, i_last);
                predicted.last = i_last;
                cipher_expect_q.push_back(predicted);
                if (mode_shadow == MODE_ENCRYPT) begin
                    cipher_log.push_back(predicted);
                    n_enc_words++;
                end else begin
                    n_dec_words++;
                end
            end
            if (i_in_valid && !take) begin
                // hold payload until accepted
            end else if (word_feed_q.size() != 0 &&
                         $urandom_range(99) >= sender_idle_pct) begin
                nxt = word_feed_q.pop_front();
                i_in_valid  <= 1'b1;
                i_data_word <= nxt.word;
                i_last      <= nxt.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: check each transfer against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_block_word exp_item;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (cipher_expect_q.size() == 0) begin
                    $error("unexpected result: result_word=%08h last_out=%0b",
                           o_result_word, o_last_out);
                    err_count++;
                end else begin
                    exp_item = cipher_expect_q.pop_front();
                    if (o_result_word !== exp_item.word) begin
                        $error("result_word: expected %08h, actual %08h",
                               exp_item.word, o_result_word);
                        err_count++;
                    end
                    if (o_last_out !== exp_item.last) begin
                        $error("last_out: expected %0b, actual %0b",
                               exp_item.last, o_last_out);
                        err_count++;
                    end
                    if (exp_item.last) begin
                        n_blocks++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus: directed words, then encrypt and replayed decrypt phases
    initial begin : stimulus
        t_block_word replay;
        t_word       phase_key;
        build_mix_table();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: key 0, encrypt; extremes and single-word blocks
        push_word(32'h0000_0000, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hAAAA_5555, 1'b1);
        push_word(32'h8000_0001, 1'b1);
        drain();

        // All-ones key, decrypt; leave the last block open
        write_reg(CFG_KEY, 32'hFFFF_FFFF);
        write_reg(CFG_MODE, {31'b0, MODE_DECRYPT});
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'h0000_0000, 1'b1);
        push_word(32'h1234_5678, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            if (p % 2 == 0) begin
                // New key and encrypt mode, often while a block is still open
                if (p == 0) begin
                    phase_key = '0;
                end else if (p == 2) begin
                    phase_key = '1;
                end else begin
                    phase_key = $urandom;
                end
                write_reg(CFG_KEY, phase_key);
                write_reg(CFG_MODE, {31'b0, MODE_ENCRYPT});
                cipher_log.delete();
                queue_random_blocks(WORDS_PER_PHASE);
            end else begin
                // Decrypt the ciphertext just produced under the same key
                write_reg(CFG_MODE, {31'b0, MODE_DECRYPT});
                for (int k = 0; k < cipher_log.size(); k++) begin
                    replay = cipher_log[k];
                    if (k == cipher_log.size() - 1 && $urandom_range(1) == 0) begin
                        replay.last = 1'b0;
                    end
                    word_feed_q.push_back(replay);
                end
            end
            drain();
        end

        $display("Covered %0d encrypt and %0d decrypt words in %0d closed blocks,",
                 n_enc_words, n_dec_words, n_blocks);
        $display("across %0d phases of sender idle and receiver stall.", N_PHASES);
        if (err_count == 0 && cipher_expect_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
